>>> hdl/rgb_ratio_color_classifier_macros.svh
// Assertion helpers used by the checker rrcc_checker.
// Each macro samples on clk and is switched off while rst is high.
`ifndef RGB_RATIO_COLOR_CLASSIFIER_MACROS_SVH
`define RGB_RATIO_COLOR_CLASSIFIER_MACROS_SVH

// The consequent must hold in the cycle where the antecedent ends.
`define RRCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent ends.
`define RRCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/rrcc_pkg.sv
`default_nettype none

package rrcc_pkg;

  typedef logic [3:0] color_t;

  localparam color_t COLOR_UNKNOWN = 4'd0;
  localparam color_t COLOR_GREEN   = 4'd1;
  localparam color_t COLOR_RED     = 4'd2;
  localparam color_t COLOR_BLUE    = 4'd3;
  localparam color_t COLOR_YELLOW  = 4'd4;
  localparam color_t COLOR_VIOLET  = 4'd5;
  localparam color_t COLOR_GREY    = 4'd6;
  localparam color_t COLOR_ORANGE  = 4'd7;
  localparam color_t COLOR_PINK    = 4'd8;
  localparam color_t COLOR_BROWN   = 4'd9;
  localparam color_t COLOR_BLACK   = 4'd10;

  // Number of window rules, checked in priority order from index 0.
  localparam int NUM_RULES = 11;

  localparam color_t RULE_COLOR [NUM_RULES] = '{
    COLOR_GREEN, COLOR_RED, COLOR_BLUE, COLOR_YELLOW, COLOR_VIOLET, COLOR_VIOLET,
    COLOR_GREY, COLOR_ORANGE, COLOR_PINK, COLOR_BROWN, COLOR_BLACK
  };

  // Ratio thresholds are in hundredths; count/2.5 is compared as 2*count vs 5*K.
  localparam int RATIO_SCALE = 100;
  localparam int SCALE_MUL   = 2;
  localparam int SCALE_DIV   = 5;

endpackage

`default_nettype wire

>>> hdl/rgb_ratio_color_classifier.sv
// RGB ratio color classifier.
//
// Input channel: in_valid/in_ready carry one request of three period counts
// (red_count, blue_count, green_count), each COUNT_WIDTH bits unsigned.
// Output channel: out_valid/out_ready carry one color_code per request,
// in request order (0 unknown, 1 green ... 10 black).
//
// The work runs through three register stages: the first scales the red
// and blue counts by 100, the second does all window compares as constant
// cross-multiplications and forms one hit bit per rule, the third picks the
// first hit in priority order into the output register. Throughput is one
// request per cycle while the receiver keeps out_ready high; every stage
// holds its own valid bit.
//
// When the receiver stalls, the output register holds its result and the
// stages behind it fill up; in_ready drops only once every stage is full, so
// nothing is lost or repeated. Reset (rst, synchronous, active high) clears
// all valid bits, empties the pipeline and leaves in_ready high.
`default_nettype none

module rgb_ratio_color_classifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COUNT_WIDTH-1:0] red_count,
  input  wire logic [COUNT_WIDTH-1:0] blue_count,
  input  wire logic [COUNT_WIDTH-1:0] green_count,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output rrcc_pkg::color_t            color_code
);
  import rrcc_pkg::*;

  localparam int W  = COUNT_WIDTH;
  // Product width: a count times a threshold of at most 255 hundredths.
  localparam int PW = W + 8;
  // Doubled count width for the 1/2.5 scaled tests.
  localparam int SW = W + 1;

  // A ratio num/den lies strictly inside (lo/100, hi/100).
  function automatic logic ratio_in(input logic [PW-1:0] num100,
                                    input logic [W-1:0] den,
                                    input int lo, input int hi);
    logic [PW-1:0] d;
    d = PW'(den);
    return (num100 > PW'(lo) * d) && (num100 < PW'(hi) * d);
  endfunction

  // A count divided by 2.5 lies strictly inside (lo, hi).
  function automatic logic scaled_in(input logic [W-1:0] cnt, input int lo, input int hi);
    logic [SW-1:0] c2;
    c2 = SW'(cnt) * SW'(SCALE_MUL);
    return (c2 > SW'(lo * SCALE_DIV)) && (c2 < SW'(hi * SCALE_DIV));
  endfunction

  // Stage enables: a stage loads when it is empty or its successor moves on.
  logic en1, en2, en3;
  logic v1, v2, v3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: capture the counts, scale red and blue by 100, flag a zero count.
  logic [W-1:0]  r1, b1, g1;
  logic [PW-1:0] r100, b100;
  logic          zero1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      r1    <= red_count;
      b1    <= blue_count;
      g1    <= green_count;
      r100  <= PW'(red_count) * PW'(RATIO_SCALE);
      b100  <= PW'(blue_count) * PW'(RATIO_SCALE);
      zero1 <= (red_count == '0) || (blue_count == '0) || (green_count == '0);
    end
  end

  // Stage 2: every window compare of every rule, folded into one hit per rule.
  logic [NUM_RULES-1:0] hit_next, hit2;
  logic                 zero2;

  always_comb begin
    hit_next[0]  = ratio_in(r100, b1, 80, 142) && ratio_in(r100, g1, 90, 135) &&
                   ratio_in(b100, g1, 89, 124);
    hit_next[1]  = ratio_in(r100, b1, 52, 72) && ratio_in(r100, g1, 41, 158) &&
                   ratio_in(b100, g1, 74, 84);
    hit_next[2]  = ratio_in(r100, b1, 116, 255) && ratio_in(r100, g1, 86, 158) &&
                   ratio_in(b100, g1, 54, 73) && scaled_in(r1, 287, 511);
    hit_next[3]  = ratio_in(r100, b1, 52, 87) && ratio_in(r100, g1, 68, 89) &&
                   ratio_in(b100, g1, 119, 150);
    hit_next[4]  = ratio_in(r100, b1, 104, 152) && ratio_in(r100, g1, 75, 99) &&
                   ratio_in(b100, g1, 61, 80) && scaled_in(r1, 205, 290) &&
                   scaled_in(b1, 178, 226);
    hit_next[5]  = ratio_in(r100, b1, 112, 152) && ratio_in(r100, g1, 75, 86) &&
                   ratio_in(b100, g1, 61, 80) && scaled_in(r1, 205, 430) &&
                   scaled_in(b1, 178, 380) && scaled_in(g1, 244, 560);
    hit_next[6]  = ratio_in(r100, b1, 109, 133) && ratio_in(r100, g1, 90, 107) &&
                   ratio_in(b100, g1, 75, 87) && scaled_in(b1, 46, 187);
    hit_next[7]  = ratio_in(r100, b1, 57, 99) && ratio_in(r100, g1, 64, 74) &&
                   ratio_in(b100, g1, 89, 115);
    hit_next[8]  = ratio_in(r100, b1, 59, 106) && ratio_in(r100, g1, 37, 72) &&
                   ratio_in(b100, g1, 62, 70);
    hit_next[9]  = ratio_in(r100, b1, 84, 109) && ratio_in(r100, g1, 70, 88) &&
                   ratio_in(b100, g1, 76, 87) && scaled_in(r1, 277, 481) &&
                   scaled_in(b1, 313, 463);
    hit_next[10] = ratio_in(r100, b1, 114, 122) && ratio_in(b100, g1, 76, 83) &&
                   scaled_in(r1, 379, 481);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      hit2  <= hit_next;
      zero2 <= zero1;
    end
  end

  // Stage 3: the lowest-numbered rule that hits gives the color; a zero count gives unknown.
  color_t code_next;

  always_comb begin
    code_next = COLOR_UNKNOWN;
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if (hit2[i]) begin
        code_next = RULE_COLOR[i];
      end
    end
    if (zero2) begin
      code_next = COLOR_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3 && v2) begin
      color_code <= code_next;
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

>>> hdl/rrcc_checker.sv
`default_nettype none
`include "rgb_ratio_color_classifier_macros.svh"

module rrcc_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [COUNT_WIDTH-1:0] red_count,
  input wire logic [COUNT_WIDTH-1:0] blue_count,
  input wire logic [COUNT_WIDTH-1:0] green_count,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [3:0]             color_code
);
  import rrcc_pkg::*;

  logic in_acc;
  logic zero_in;

  assign in_acc  = in_valid && in_ready;
  assign zero_in = (red_count == '0) || (blue_count == '0) || (green_count == '0);

  // A stalled result stays put.
  `RRCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(color_code))

  // With the output register empty, the whole pipeline can take a request.
  `RRCC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // An accepted request reaches out_valid when the receiver does not stall.
  `RRCC_ASSERT_NEXT(a_latency, in_acc ##1 out_ready ##1 out_ready, out_valid)

  // Any zero count classifies as unknown.
  `RRCC_ASSERT_NEXT(a_zero_unknown, (in_acc && zero_in) ##1 out_ready ##1 out_ready,
                    out_valid && (color_code == COLOR_UNKNOWN))

endmodule

bind rgb_ratio_color_classifier rrcc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_rrcc_checker (.*);

`default_nettype wire
